### hw/rtl/property_table_parser_defines.svh
// ----------------------------------------------------------------------------
// property_table_parser_defines.svh
// Assertion macros for the property table parser checks.
// The enclosing module must provide the signals clk and rst.
// ----------------------------------------------------------------------------
`ifndef PROPERTY_TABLE_PARSER_DEFINES_SVH
`define PROPERTY_TABLE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PTP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("property table parser check failed");

// Next-cycle implication, disabled during reset.
`define PTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("property table parser check failed");

`endif

### hw/rtl/ptp_pkg.sv
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared constants and types of the property table parser.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int MAX_IDS_DEFAULT = 64;
  localparam int QUEUE_DEPTH     = 4;

  // result kinds
  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_EARLY_END = 2'd0;
  localparam logic [1:0] ERR_ID_WIDE   = 2'd1;
  localparam logic [1:0] ERR_TOO_MANY  = 2'd2;

  // work command from the front to the back
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] error_code;
    logic [7:0] type_byte;
    logic [1:0] n_minus1;   // entries in the group, minus one
    logic       last_grp;   // group holds the final result of the table
  } cmd_t;

endpackage

### hw/rtl/ptp_byte_if.sv
// ----------------------------------------------------------------------------
// ptp_byte_if
// Byte stream channel: valid/ready with one stream byte and its flags.
// ----------------------------------------------------------------------------
interface ptp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       stream_end;
  logic       restart;

  modport source (output valid, byte_in, stream_end, restart, input ready);
  modport sink   (input valid, byte_in, stream_end, restart, output ready);
  modport monitor (input valid, ready, byte_in, stream_end, restart);
endinterface

### hw/rtl/ptp_result_if.sv
// ----------------------------------------------------------------------------
// ptp_result_if
// Result channel: valid/ready with one id/type entry, done or error result.
// ----------------------------------------------------------------------------
interface ptp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] prop_id;
  logic [1:0]  prop_type;
  logic [1:0]  error_code;
  logic        last;

  modport source (output valid, kind, prop_id, prop_type, error_code, last,
                  input ready);
  modport sink   (input valid, kind, prop_id, prop_type, error_code, last,
                  output ready);
  modport monitor (input valid, ready, kind, prop_id, prop_type, error_code, last);
endinterface

### hw/rtl/ptp_front.sv
// ----------------------------------------------------------------------------
// ptp_front
// Byte parser: decodes LEB128 ids into the id store, gathers type words and
// issues work commands to the command queue.
// ----------------------------------------------------------------------------
module ptp_front #(
  parameter int MAX_IDS = ptp_pkg::MAX_IDS_DEFAULT,
  localparam int IDX_W  = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  ptp_byte_if.sink              byte_ch,
  input  logic                  q_full,
  input  logic                  drain_busy,
  output logic                  push,
  output ptp_pkg::cmd_t         cmd,
  output logic [IDX_W-1:0]      cmd_base,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output logic [31:0]           wr_data
);

  localparam int CNT_W = $clog2(MAX_IDS + 1);
  localparam logic [4:0] SHIFT_LAST = 5'd28;
  localparam logic [4:0] SHIFT_STEP = 5'd7;

  typedef enum logic [1:0] {PH_IDS, PH_TYPES, PH_WAIT} phase_t;

  phase_t           phase, phase_e, phase_next;
  logic [31:0]      accum, accum_e, accum_next;
  logic [4:0]       shift, shift_e, shift_next;
  logic [CNT_W-1:0] count, count_e, count_next;
  logic [CNT_W-1:0] emit, emit_e, emit_next;
  logic [1:0]       wbc, wbc_e, wbc_next;
  logic [7:0]       tb, tb_e, tb_next;

  logic             accept;
  logic             push_c;
  logic             wr_c;
  logic [6:0]       payload;
  logic             more;
  logic [31:0]      accum_or;
  logic [CNT_W-1:0] rem;
  logic [7:0]       tb_cur;

  // a restart waits until older entries are out of the id store
  assign byte_ch.ready = !q_full && !(byte_ch.restart && drain_busy);
  assign accept        = byte_ch.valid && byte_ch.ready;
  assign push          = accept && push_c;
  assign wr_en         = accept && wr_c;
  assign wr_addr       = count_e[IDX_W-1:0];
  assign wr_data       = accum_or;

  assign payload  = byte_ch.byte_in[6:0];
  assign more     = byte_ch.byte_in[7];
  assign accum_or = accum_e | ({25'd0, payload} << shift_e);
  assign rem      = count_e - emit_e;
  assign tb_cur   = (wbc_e == 2'd0) ? byte_ch.byte_in : tb_e;

  always_comb begin
    phase_e = phase;
    accum_e = accum;
    shift_e = shift;
    count_e = count;
    emit_e  = emit;
    wbc_e   = wbc;
    tb_e    = tb;
    if (byte_ch.restart) begin
      phase_e = PH_IDS;
      accum_e = '0;
      shift_e = '0;
      count_e = '0;
      emit_e  = '0;
      wbc_e   = '0;
      tb_e    = '0;
    end

    phase_next = phase_e;
    accum_next = accum_e;
    shift_next = shift_e;
    count_next = count_e;
    emit_next  = emit_e;
    wbc_next   = wbc_e;
    tb_next    = tb_e;
    push_c     = 1'b0;
    wr_c       = 1'b0;
    cmd        = '0;
    cmd_base   = '0;

    unique case (phase_e)
      PH_IDS: begin
        if (byte_ch.stream_end) begin
          phase_next     = PH_WAIT;
          push_c         = 1'b1;
          cmd.kind       = ptp_pkg::KIND_ERROR;
          cmd.error_code = ptp_pkg::ERR_EARLY_END;
          cmd.last_grp   = 1'b1;
        end else if (shift_e >= SHIFT_LAST && (payload[6:4] != 3'd0 || more)) begin
          phase_next     = PH_WAIT;
          push_c         = 1'b1;
          cmd.kind       = ptp_pkg::KIND_ERROR;
          cmd.error_code = ptp_pkg::ERR_ID_WIDE;
          cmd.last_grp   = 1'b1;
        end else if (more) begin
          accum_next = accum_or;
          shift_next = shift_e + SHIFT_STEP;
        end else begin
          accum_next = '0;
          shift_next = '0;
          if (accum_or == 32'd0) begin
            if (count_e == '0) begin
              phase_next   = PH_WAIT;
              push_c       = 1'b1;
              cmd.kind     = ptp_pkg::KIND_DONE;
              cmd.last_grp = 1'b1;
            end else begin
              phase_next = PH_TYPES;
              emit_next  = '0;
              wbc_next   = '0;
            end
          end else if (count_e == CNT_W'(MAX_IDS)) begin
            phase_next     = PH_WAIT;
            push_c         = 1'b1;
            cmd.kind       = ptp_pkg::KIND_ERROR;
            cmd.error_code = ptp_pkg::ERR_TOO_MANY;
            cmd.last_grp   = 1'b1;
          end else begin
            wr_c       = 1'b1;
            count_next = count_e + CNT_W'(1);
          end
        end
      end
      PH_TYPES: begin
        if (byte_ch.stream_end) begin
          phase_next     = PH_WAIT;
          push_c         = 1'b1;
          cmd.kind       = ptp_pkg::KIND_ERROR;
          cmd.error_code = ptp_pkg::ERR_EARLY_END;
          cmd.last_grp   = 1'b1;
        end else begin
          tb_next = tb_cur;
          if (wbc_e != 2'd3) begin
            wbc_next = wbc_e + 2'd1;
          end else begin
            // fourth byte of the word: one group of up to four entries
            wbc_next      = '0;
            push_c        = 1'b1;
            cmd.kind      = ptp_pkg::KIND_ENTRY;
            cmd.type_byte = tb_cur;
            cmd.n_minus1  = (32'(rem) >= 4) ? 2'd3 : 2'(rem - CNT_W'(1));
            cmd_base      = emit_e[IDX_W-1:0];
            emit_next     = emit_e + CNT_W'({1'b0, cmd.n_minus1} + 3'd1);
            cmd.last_grp  = (emit_next == count_e);
            if (emit_next == count_e) begin
              phase_next = PH_WAIT;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDS;
      accum <= '0;
      shift <= '0;
      count <= '0;
      emit  <= '0;
      wbc   <= '0;
      tb    <= '0;
    end else if (accept) begin
      phase <= phase_next;
      accum <= accum_next;
      shift <= shift_next;
      count <= count_next;
      emit  <= emit_next;
      wbc   <= wbc_next;
      tb    <= tb_next;
    end
  end

endmodule

### hw/rtl/ptp_queue.sv
// ----------------------------------------------------------------------------
// ptp_queue
// Small register FIFO carrying work commands from the front to the back.
// ----------------------------------------------------------------------------
module ptp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ptp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

### hw/rtl/ptp_back.sv
// ----------------------------------------------------------------------------
// ptp_back
// Result engine: holds the id store, expands commands into one result per cycle,
// while the output is free, through a read stage and an output register.
// ----------------------------------------------------------------------------
module ptp_back #(
  parameter int MAX_IDS = ptp_pkg::MAX_IDS_DEFAULT,
  localparam int IDX_W  = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  ptp_pkg::cmd_t         q_cmd,
  input  logic [IDX_W-1:0]      q_base,
  output logic                  q_pop,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [31:0]           wr_data,
  output logic                  busy,
  ptp_result_if.source          result_ch
);

  logic [31:0] id_store [MAX_IDS];
  logic [31:0] rdata;

  // active command
  logic             grp_valid;
  logic [1:0]       grp_kind;
  logic [1:0]       grp_code;
  logic [IDX_W-1:0] grp_idx;
  logic [1:0]       grp_left;
  logic [7:0]       grp_types;
  logic             grp_last;

  // read stage
  logic       s1_valid;
  logic [1:0] s1_kind;
  logic [1:0] s1_code;
  logic [1:0] s1_type;
  logic       s1_last;

  // output register
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [31:0] out_id;
  logic [1:0]  out_type;
  logic [1:0]  out_code;
  logic        out_last;

  logic out_free, s1_adv, s1_free, issue;

  assign out_free = !out_valid || result_ch.ready;
  assign s1_adv   = s1_valid && out_free;
  assign s1_free  = !s1_valid || s1_adv;
  assign issue    = grp_valid && s1_free;
  assign q_pop    = !grp_valid && q_valid;
  assign busy     = grp_valid;

  assign result_ch.valid      = out_valid;
  assign result_ch.kind       = out_kind;
  assign result_ch.prop_id    = out_id;
  assign result_ch.prop_type  = out_type;
  assign result_ch.error_code = out_code;
  assign result_ch.last       = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        grp_valid <= 1'b1;
      end else if (issue && grp_left == 2'd0) begin
        grp_valid <= 1'b0;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      grp_kind  <= q_cmd.kind;
      grp_code  <= q_cmd.error_code;
      grp_idx   <= q_base;
      grp_left  <= q_cmd.n_minus1;
      grp_types <= q_cmd.type_byte;
      grp_last  <= q_cmd.last_grp;
    end else if (issue) begin
      grp_idx   <= grp_idx + IDX_W'(1);
      grp_left  <= grp_left - 2'd1;
      grp_types <= {2'b00, grp_types[7:2]};
    end
    if (issue) begin
      s1_kind <= grp_kind;
      s1_code <= grp_code;
      s1_type <= grp_types[1:0];
      s1_last <= grp_last && (grp_left == 2'd0);
    end
    if (s1_adv) begin
      out_kind <= s1_kind;
      out_id   <= (s1_kind == ptp_pkg::KIND_ENTRY) ? rdata : 32'd0;
      out_type <= s1_type;
      out_code <= s1_code;
      out_last <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_store[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata <= id_store[grp_idx];
    end
  end

endmodule

### hw/rtl/property_table_parser.sv
// Path of a result: command queue, active command, read stage, output register.
// Throughput: one byte per cycle in while the 4-deep command queue has room;
//   a group of up to 4 results (one type word) waits until the previous one is issued.
// A restart waits while older entries are still queued or being read out.
// Reset (rst, synchronous, active high) clears parser state, queue and
//   result pipeline; the id store itself is not cleared.
// ----------------------------------------------------------------------------
// property_table_parser
// LEB128 property id list and 2-bit type table parser, top level.
// ----------------------------------------------------------------------------
module property_table_parser #(
  parameter int MAX_IDS = ptp_pkg::MAX_IDS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  ptp_byte_if.sink      byte_ch,
  ptp_result_if.source  result_ch
);

  localparam int IDX_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int Q_W   = $bits(ptp_pkg::cmd_t) + IDX_W;

  // front -> queue
  logic             push;
  ptp_pkg::cmd_t    cmd;
  logic [IDX_W-1:0] cmd_base;

  // queue -> back
  logic [Q_W-1:0]   q_head;
  logic             q_empty, q_full, q_pop;
  ptp_pkg::cmd_t    q_cmd;
  logic [IDX_W-1:0] q_base;

  // id store write port, driven by the front, stored in the back
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_data;

  logic back_busy;
  logic drain_busy;

  // Any queued or active command may still need the id store, so a new
  // table must not start overwriting it until the back has picked it all up.
  assign drain_busy = !q_empty || back_busy;

  assign q_cmd  = q_head[Q_W-1 -: $bits(ptp_pkg::cmd_t)];
  assign q_base = q_head[IDX_W-1:0];

  // Front: takes one byte per transfer, parses ids and type words.
  ptp_front #(.MAX_IDS(MAX_IDS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .q_full     (q_full),
    .drain_busy (drain_busy),
    .push       (push),
    .cmd        (cmd),
    .cmd_base   (cmd_base),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  // Queue: decouples the byte side from the result side.
  ptp_queue #(.WIDTH(Q_W), .DEPTH(ptp_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({cmd, cmd_base}),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Back: reads the id store and sends one result per transfer.
  ptp_back #(.MAX_IDS(MAX_IDS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_empty),
    .q_cmd     (q_cmd),
    .q_base    (q_base),
    .q_pop     (q_pop),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .busy      (back_busy),
    .result_ch (result_ch)
  );

endmodule

### hw/rtl/ptp_checker.sv
// ----------------------------------------------------------------------------
// ptp_assert_checker
// Port-level checks of the property table parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "property_table_parser_defines.svh"

module ptp_assert_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [1:0]  kind,
  input logic [31:0] prop_id,
  input logic [1:0]  prop_type,
  input logic [1:0]  error_code,
  input logic        last
);

  localparam logic [1:0] NO_CODE = 2'd0;
  localparam logic [1:0] NO_TYPE = 2'd0;

  logic        stalled;
  logic        is_entry;
  logic        final_ok;
  logic [38:0] payload;

  assign stalled  = valid && !ready;
  assign is_entry = (kind == ptp_pkg::KIND_ENTRY);
  assign final_ok = last && prop_id == 32'd0 && prop_type == NO_TYPE;
  assign payload  = {kind, prop_id, prop_type, error_code, last};

  `PTP_ASSERT_NEXT(a_valid_holds, stalled, valid)
  `PTP_ASSERT_NEXT(a_payload_holds, stalled, $stable(payload))
  `PTP_ASSERT_NOW(a_final_shape, valid && !is_entry, final_ok)
  `PTP_ASSERT_NOW(a_entry_no_code, valid && is_entry, error_code == NO_CODE)

endmodule

bind property_table_parser ptp_assert_checker u_ptp_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (result_ch.valid),
  .ready      (result_ch.ready),
  .kind       (result_ch.kind),
  .prop_id    (result_ch.prop_id),
  .prop_type  (result_ch.prop_type),
  .error_code (result_ch.error_code),
  .last       (result_ch.last)
);

### tb/ptp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptp_checker
// Watches the byte and result channels of the property table parser, keeps
// its own copy of the parser state, predicts the results of every byte
// transfer and compares each result transfer, field by field, in order.
// ----------------------------------------------------------------------------
module ptp_checker #(
  parameter int MAX_IDS = ptp_pkg::MAX_IDS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  ptp_byte_if.monitor     byte_ch,
  ptp_result_if.monitor   result_ch,
  output int              fail_count,
  output int              pending
);

  localparam logic [1:0] NO_CODE = 2'd0;
  localparam logic [1:0] NO_TYPE = 2'd0;

  typedef enum logic [1:0] {
    PH_READ_IDS,
    PH_READ_TYPES,
    PH_FINISHED
  } table_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] prop_id;
    logic [1:0]  prop_type;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

  table_phase_t phase;
  logic [31:0]  id_accum;
  logic [5:0]   id_shift;
  logic [31:0]  id_store [MAX_IDS];
  int           id_count;
  int           emit_index;
  logic [1:0]   word_bytes;
  logic [7:0]   type_byte;
  result_t      due_results [$];

  task automatic clear_table();
    phase      = PH_READ_IDS;
    id_accum   = '0;
    id_shift   = '0;
    id_count   = 0;
    emit_index = 0;
    word_bytes = '0;
    type_byte  = '0;
  endtask

  task automatic add_result(input logic [1:0] kind, input logic [31:0] id,
                            input logic [1:0] ptype, input logic [1:0] code,
                            input logic last);
    result_t r;
    r.kind       = kind;
    r.prop_id    = id;
    r.prop_type  = ptype;
    r.error_code = code;
    r.last       = last;
    due_results.insert(due_results.size(), r);
  endtask

  task automatic raise_error(input logic [1:0] code);
    phase = PH_FINISHED;
    add_result(ptp_pkg::KIND_ERROR, '0, NO_TYPE, code, 1'b1);
  endtask

  // One byte transfer: LEB128 id list, then 32-bit type words.
  task automatic parse_byte(input logic [7:0] b, input logic stream_end,
                            input logic restart);
    logic [6:0]  payload;
    logic        more;
    logic [31:0] id;
    int          f;
    if (restart) clear_table();
    if (phase == PH_FINISHED) return;
    if (stream_end) begin
      raise_error(ptp_pkg::ERR_EARLY_END);
      return;
    end
    if (phase == PH_READ_IDS) begin
      payload = b[6:0];
      more    = b[7];
      if (id_shift >= 6'd28) begin
        // fifth group may only carry bits 31:28
        if (payload[6:4] != 3'd0 || more) begin
          raise_error(ptp_pkg::ERR_ID_WIDE);
          return;
        end
        id_accum = id_accum | {payload[3:0], 28'd0};
      end else begin
        id_accum = id_accum | (32'(payload) << id_shift);
      end
      if (more) begin
        id_shift = id_shift + 6'd7;
        return;
      end
      id       = id_accum;
      id_accum = '0;
      id_shift = '0;
      if (id == 32'd0) begin
        if (id_count == 0) begin
          phase = PH_FINISHED;
          add_result(ptp_pkg::KIND_DONE, '0, NO_TYPE, NO_CODE, 1'b1);
        end else begin
          phase      = PH_READ_TYPES;
          emit_index = 0;
          word_bytes = '0;
        end
        return;
      end
      if (id_count >= MAX_IDS) begin
        raise_error(ptp_pkg::ERR_TOO_MANY);
        return;
      end
      id_store[id_count] = id;
      id_count++;
      return;
    end
    // type words: low byte carries four 2-bit types, the rest is skipped
    if (word_bytes == 2'd0) type_byte = b;
    if (word_bytes != 2'd3) begin
      word_bytes = word_bytes + 2'd1;
      return;
    end
    word_bytes = '0;
    for (f = 0; f < 4 && emit_index < id_count; f++) begin
      add_result(ptp_pkg::KIND_ENTRY, id_store[emit_index], type_byte[2*f +: 2],
                 NO_CODE, emit_index + 1 == id_count);
      emit_index++;
    end
    if (emit_index >= id_count) phase = PH_FINISHED;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ptp_checker: %s mismatch, expected %0h actual %0h",
               $time, name, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      fail_count++;
      $display("%0t ptp_checker: unexpected result, expected none, actual kind %0d id %0h %s",
               $time, result_ch.kind, result_ch.prop_id,
               $sformatf("type %0d code %0d last %0b", result_ch.prop_type,
                         result_ch.error_code, result_ch.last));
      return;
    end
    want = due_results.pop_front();
    check_field("kind", 32'(want.kind), 32'(result_ch.kind));
    check_field("prop_id", want.prop_id, result_ch.prop_id);
    check_field("prop_type", 32'(want.prop_type), 32'(result_ch.prop_type));
    check_field("error_code", 32'(want.error_code), 32'(result_ch.error_code));
    check_field("last", 32'(want.last), 32'(result_ch.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_table();
      due_results.delete();
    end else begin
      // compare first: a result never stems from the byte of the same edge
      if (result_ch.valid && result_ch.ready) check_result();
      if (byte_ch.valid && byte_ch.ready)
        parse_byte(byte_ch.byte_in, byte_ch.stream_end, byte_ch.restart);
    end
    pending = due_results.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the property table parser: directed tables, then
// random tables (well-formed, cut short, malformed, noise) with random idle
// cycles on both channels; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_IDS      = ptp_pkg::MAX_IDS_DEFAULT;
  localparam int ITEM_TARGET  = 480;   // counted byte transfers
  localparam int STALL_LIMIT  = 2000;  // cycles with no transfer at all
  localparam int DRAIN_CYCLES = 12;    // margin for stray results
  localparam int STEADY_FROM  = 240;   // window without idle cycles
  localparam int STEADY_TO    = 340;

  logic clk = 1'b0;
  logic rst;
  logic steady = 1'b0;   // no idling on either side while high
  int   fail_count;
  int   pending;
  int   items_sent = 0;
  int   quiet_cycles = 0;

  // pending table stream: bit 8 is the stream end flag, 7:0 the byte
  logic [8:0] stream_q [$];

  ptp_byte_if   byte_ch ();
  ptp_result_if result_ch ();

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  property_table_parser #(.MAX_IDS(MAX_IDS)) dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  ptp_checker #(.MAX_IDS(MAX_IDS)) result_check (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .result_ch  (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side: ready low in about 30% of cycles, except in the steady window.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= steady || ($urandom_range(0, 99) >= 30);
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---- stream building ----

  function void push_byte(input logic [7:0] b);
    stream_q.insert(stream_q.size(), {1'b0, b});
  endfunction

  function void push_end();
    stream_q.insert(stream_q.size(), {1'b1, 8'($urandom)});
  endfunction

  // LEB128, low group first; now and then one redundant zero group
  function void push_id(input logic [31:0] id);
    logic [31:0] v;
    int          n;
    v = id;
    n = 0;
    do begin
      push_byte({v[31:7] != 25'd0, v[6:0]});
      v = v >> 7;
      n++;
    end while (v != 32'd0);
    if (n < 5 && $urandom_range(0, 9) == 0) begin
      stream_q[stream_q.size() - 1][7] = 1'b1;
      push_byte(8'h00);
    end
  endfunction

  function logic [31:0] random_id(input bit narrow);
    logic [31:0] v;
    if (narrow) begin
      v = 32'($urandom_range(1, 127));
    end else begin
      v = $urandom >> $urandom_range(0, 31);
      if (v == 32'd0) v = 32'd1;
    end
    return v;
  endfunction

  function int pick_count();
    if ($urandom_range(0, 99) < 5) return $urandom_range(30, MAX_IDS);
    return $urandom_range(1, 9);
  endfunction

  // n ids, zero terminator, then whole type words; n = 0 is the empty table
  function void build_table(input int n, input bit narrow);
    int i;
    for (i = 0; i < n; i++) push_id(random_id(narrow));
    push_id(32'd0);
    for (i = 0; i < (n + 3) / 4 * 4; i++) push_byte(8'($urandom));
  endfunction

  function void cut_stream(input int keep);
    while (stream_q.size() > keep) stream_q.delete(stream_q.size() - 1);
  endfunction

  // ---- driving ----

  // One byte transfer. Called at a rising edge, returns at the accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic stream_end,
                           input logic restart, input bit counted);
    logic taken;
    steady <= (items_sent >= STEADY_FROM) && (items_sent < STEADY_TO);
    while (!steady && $urandom_range(0, 99) < 30) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.byte_in    <= b;
    byte_ch.stream_end <= stream_end;
    byte_ch.restart    <= restart;
    // ready is settled by the falling edge; it decides the next rising edge
    forever begin
      @(negedge clk);
      taken = byte_ch.ready;
      @(posedge clk);
      if (taken) break;
    end
    if (counted) items_sent++;
  endtask

  // Sends the built stream with restart on its first byte. A finished table
  // may be followed by a few bytes that the block must ignore.
  task automatic send_table(input bit finished);
    int i;
    for (i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i][7:0], stream_q[i][8], i == 0, 1'b1);
    stream_q.delete();
    if (finished && $urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 3))
        send_byte(8'($urandom), $urandom_range(0, 9) == 0, 1'b0, 1'b0);
    end
  endtask

  initial begin
    int r;
    int cut;
    rst                = 1'b1;
    byte_ch.valid      = 1'b0;
    byte_ch.byte_in    = 8'h00;
    byte_ch.stream_end = 1'b0;
    byte_ch.restart    = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // -- directed tables --
    // empty list, then a byte that must be ignored
    push_byte(8'h00);
    send_table(1'b0);
    send_byte(8'h55, 1'b0, 1'b0, 1'b0);
    // widest id, one-byte extremes, two-byte id, all four types in one word
    push_byte(8'hff); push_byte(8'hff); push_byte(8'hff); push_byte(8'hff);
    push_byte(8'h0f);
    push_byte(8'h01);
    push_byte(8'h7f);
    push_byte(8'h80); push_byte(8'h01);
    push_byte(8'h00);
    push_byte(8'he4); push_byte(8'hff); push_byte(8'hff); push_byte(8'hff);
    send_table(1'b0);
    // fifth group carries bit 32
    push_byte(8'h80); push_byte(8'h80); push_byte(8'h80); push_byte(8'h80);
    push_byte(8'h10);
    send_table(1'b0);
    // end mark together with restart
    push_end();
    send_table(1'b0);
    // stream ends inside the type word
    push_byte(8'h05); push_byte(8'h00); push_byte(8'he4);
    push_end();
    send_table(1'b0);

    // -- store full: once as an error, once exactly at capacity --
    repeat (MAX_IDS) push_id(random_id(1'b1));
    push_id(random_id(1'b0));
    send_table(1'b1);
    build_table(MAX_IDS, 1'b1);
    send_table(1'b1);

    // -- random tables --
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        build_table(pick_count(), 1'b0);
        send_table(1'b1);
      end else if (r < 67) begin
        // early end at any point of a well-formed table
        build_table(pick_count(), 1'b0);
        cut_stream($urandom_range(0, stream_q.size() - 1));
        push_end();
        send_table(1'b1);
      end else if (r < 75) begin
        // id wider than 32 bits
        repeat ($urandom_range(0, 5)) push_id(random_id(1'b0));
        repeat (4) push_byte(8'h80 | 8'($urandom));
        push_byte(8'($urandom_range(16, 255)));
        send_table(1'b1);
      end else if (r < 80) begin
        build_table(0, 1'b0);
        send_table(1'b1);
      end else if (r < 82) begin
        repeat (MAX_IDS) push_id(random_id(1'b1));
        push_id(random_id(1'b0));
        send_table(1'b1);
      end else if (r < 90) begin
        // raw noise
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 9) == 0) push_end();
          else push_byte(8'($urandom));
        end
        send_table(1'b0);
      end else begin
        // table broken off by the next restart
        build_table(pick_count(), 1'b0);
        cut = $urandom_range(1, stream_q.size() - 1);
        cut_stream(cut);
        send_table(1'b0);
      end
    end
    byte_ch.valid <= 1'b0;

    // drain: all predicted results in, then a few more cycles for strays
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ptp_pkg.sv
hw/rtl/ptp_byte_if.sv
hw/rtl/ptp_result_if.sv
hw/rtl/ptp_front.sv
hw/rtl/ptp_queue.sv
hw/rtl/ptp_back.sv
hw/rtl/property_table_parser.sv
hw/rtl/ptp_checker.sv
tb/ptp_checker.sv
tb/tb.sv
